[sv/three_nearest_neighbour_classify_core_defines.svh]
// assertion macros for the classifier rtl, included by tnnc_slots
`ifndef THREE_NEAREST_NEIGHBOUR_CLASSIFY_CORE_DEFINES_SVH
`define THREE_NEAREST_NEIGHBOUR_CLASSIFY_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define TNNC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tnnc assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define TNNC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tnnc assertion failed");

`endif

[sv/tnnc_pkg.sv]
// types and constants of the three-nearest-neighbour classifier
`default_nettype none

package tnnc_pkg;

  localparam int VALUE_BITS = 16;
  localparam int CLASS_BITS = 8;
  localparam int DIST_BITS  = 38;
  localparam int CNT_BITS   = 7;
  localparam int SQ_BITS    = 2 * VALUE_BITS;
  localparam int NSLOTS     = 3;

  localparam logic [DIST_BITS-1:0] DIST_MAX  = '1;
  localparam logic [1:0]           SEEN_FULL = 2'd3;

  typedef enum logic {
    REQ_QUERY = 1'b0,
    REQ_TRAIN = 1'b1
  } req_t;

  typedef struct packed {
    req_t                  req_type;
    logic [VALUE_BITS-1:0] attr_value;
    logic [CLASS_BITS-1:0] sample_class;
    logic                  last_sample;
  } in_word_t;

  typedef struct packed {
    logic [CLASS_BITS-1:0] predicted_class;
    logic [DIST_BITS-1:0]  nearest_distance;
    logic                  too_few_samples;
  } out_word_t;

  // one finished training sample handed to the neighbour slots
  typedef struct packed {
    logic [DIST_BITS-1:0]  sq_sum;
    logic [CLASS_BITS-1:0] cls;
    logic                  last;
  } sample_t;

endpackage

`default_nettype wire

[sv/tnnc_dist.sv]
// query store, squared difference and per-sample distance accumulation
`default_nettype none

module tnnc_dist #(
  parameter int MAX_ATTRS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tnnc_pkg::CNT_BITS-1:0] attr_count,
  input  logic                          in_valid,
  input  tnnc_pkg::in_word_t            in_word,
  output logic                          in_stall,
  output logic                          smp_valid,
  output tnnc_pkg::sample_t             smp,
  input  logic                          smp_ready
);
  import tnnc_pkg::*;

  localparam int IDX_W   = (MAX_ATTRS > 1) ? $clog2(MAX_ATTRS) : 1;
  localparam int CMP_W   = ((IDX_W > CNT_BITS) ? IDX_W : CNT_BITS) + 1;
  localparam int CNT_MAX = (1 << CNT_BITS) - 1;
  localparam int CAP     = (MAX_ATTRS < CNT_MAX) ? MAX_ATTRS : CNT_MAX;
  localparam logic [CNT_BITS-1:0] CAP_C = CNT_BITS'(CAP);

  logic [VALUE_BITS-1:0] qmem [MAX_ATTRS];

  logic [CNT_BITS-1:0] count;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt, idx;
  logic [CMP_W-1:0]    cnt_ext, idx_inc, count_ext;
  logic                sample_end, accept;

  // stage a: value and stored query attribute
  logic                  a_valid_r, a_end_r, a_last_r;
  logic [VALUE_BITS-1:0] a_val_r, a_q_r;
  logic [CLASS_BITS-1:0] a_cls_r;
  // stage b: registered square
  logic                  b_valid_r, b_end_r, b_last_r;
  logic [SQ_BITS-1:0]    b_sq_r;
  logic [CLASS_BITS-1:0] b_cls_r;
  // stage c: finished sample
  logic                  c_valid_r;
  sample_t               c_smp_r;

  logic [DIST_BITS-1:0]  acc_r, acc_sum;
  logic [DIST_BITS:0]    sum_wide;
  logic [VALUE_BITS-1:0] diff;
  logic [SQ_BITS-1:0]    sq;
  logic                  c_free, b_go, b_free, a_go, a_free;

  always_comb begin
    if (attr_count == '0) begin
      count = CNT_BITS'(1);
    end else if (attr_count > CAP_C) begin
      count = CAP_C;
    end else begin
      count = attr_count;
    end
  end

  // a count lowered under the running index restarts at zero
  assign cnt_ext    = CMP_W'(cnt_r);
  assign count_ext  = CMP_W'(count);
  assign idx        = (cnt_ext >= count_ext) ? '0 : cnt_r;
  assign idx_inc    = CMP_W'(idx) + CMP_W'(1);
  assign sample_end = (idx_inc >= count_ext);
  assign cnt_nxt    = sample_end ? '0 : idx_inc[IDX_W-1:0];

  assign c_free   = !c_valid_r || smp_ready;
  assign b_go     = b_valid_r && (!b_end_r || c_free);
  assign b_free   = !b_valid_r || b_go;
  assign a_go     = a_valid_r && b_free;
  assign a_free   = !a_valid_r || a_go;
  assign in_stall = !a_free;
  assign accept   = in_valid && a_free;

  assign diff = (a_val_r >= a_q_r) ? (a_val_r - a_q_r) : (a_q_r - a_val_r);
  assign sq   = SQ_BITS'(diff) * SQ_BITS'(diff);

  assign sum_wide = (DIST_BITS + 1)'(acc_r) + (DIST_BITS + 1)'(b_sq_r);
  assign acc_sum  = sum_wide[DIST_BITS] ? DIST_MAX : sum_wide[DIST_BITS-1:0];

  always_ff @(posedge clk) begin
    if (accept) begin
      if (in_word.req_type == REQ_QUERY) begin
        qmem[idx] <= in_word.attr_value;
      end else begin
        a_q_r <= qmem[idx];
      end
      a_val_r  <= in_word.attr_value;
      a_cls_r  <= in_word.sample_class;
      a_last_r <= in_word.last_sample;
      a_end_r  <= sample_end;
    end
    if (a_go) begin
      b_sq_r   <= sq;
      b_cls_r  <= a_cls_r;
      b_last_r <= a_last_r;
      b_end_r  <= a_end_r;
    end
    if (b_go && b_end_r) begin
      c_smp_r.sq_sum <= acc_sum;
      c_smp_r.cls    <= b_cls_r;
      c_smp_r.last   <= b_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      acc_r     <= '0;
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
      if (b_go) begin
        acc_r <= b_end_r ? '0 : acc_sum;
      end
      a_valid_r <= (accept && in_word.req_type == REQ_TRAIN) || (a_valid_r && !a_go);
      b_valid_r <= a_go || (b_valid_r && !b_go);
      c_valid_r <= (b_go && b_end_r) || (c_valid_r && !smp_ready);
    end
  end

  assign smp_valid = c_valid_r;
  assign smp       = c_smp_r;

endmodule

`default_nettype wire

[sv/tnnc_slots.sv]
// three neighbour slots, set-end snapshot and three-way vote
`default_nettype none
`include "three_nearest_neighbour_classify_core_defines.svh"

module tnnc_slots (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                smp_valid,
  input  tnnc_pkg::sample_t   smp,
  output logic                smp_ready,
  output logic                out_valid,
  output tnnc_pkg::out_word_t out_word,
  input  logic                out_stall
);
  import tnnc_pkg::*;

  logic [1:0]            seen_r, seen_nxt;
  logic [DIST_BITS-1:0]  slot_dist_r [NSLOTS];
  logic [CLASS_BITS-1:0] slot_cls_r  [NSLOTS];
  logic [DIST_BITS-1:0]  slot_dist_nxt [NSLOTS];
  logic [CLASS_BITS-1:0] slot_cls_nxt  [NSLOTS];
  logic [1:0]            far_idx;

  // snapshot of the slots at set end
  logic                  e_valid_r, e_few_r;
  logic [DIST_BITS-1:0]  e_dist_r [NSLOTS];
  logic [CLASS_BITS-1:0] e_cls_r  [NSLOTS];

  logic                  out_valid_r;
  out_word_t             out_word_r, vote_word;
  logic [DIST_BITS-1:0]  best;
  logic [1:0]            near_idx;
  logic [CLASS_BITS-1:0] win_cls;
  logic                  e_go, e_free, smp_go;

  assign e_go      = e_valid_r && (!out_valid_r || !out_stall);
  assign e_free    = !e_valid_r || e_go;
  assign smp_ready = !smp.last || e_free;
  assign smp_go    = smp_valid && smp_ready;

  // farthest slot, lowest index wins on equal distances
  always_comb begin
    far_idx = 2'd0;
    if (slot_dist_r[0] < slot_dist_r[1]) begin
      far_idx = 2'd1;
    end
    if (slot_dist_r[far_idx] < slot_dist_r[2]) begin
      far_idx = 2'd2;
    end
  end

  always_comb begin
    slot_dist_nxt = slot_dist_r;
    slot_cls_nxt  = slot_cls_r;
    seen_nxt      = seen_r;
    if (seen_r != SEEN_FULL) begin
      slot_dist_nxt[seen_r] = smp.sq_sum;
      slot_cls_nxt[seen_r]  = smp.cls;
      seen_nxt              = seen_r + 2'd1;
    end else if (smp.sq_sum < slot_dist_r[far_idx]) begin
      slot_dist_nxt[far_idx] = smp.sq_sum;
      slot_cls_nxt[far_idx]  = smp.cls;
    end
  end

  always_comb begin
    best     = e_dist_r[0];
    near_idx = 2'd0;
    for (int i = 1; i < NSLOTS; i++) begin
      if (best > e_dist_r[i]) begin
        best     = e_dist_r[i];
        near_idx = 2'(i);
      end
    end
    if (e_cls_r[0] == e_cls_r[1]) begin
      win_cls = e_cls_r[1];
    end else if (e_cls_r[1] == e_cls_r[2]) begin
      win_cls = e_cls_r[1];
    end else if (e_cls_r[0] == e_cls_r[2]) begin
      win_cls = e_cls_r[0];
    end else begin
      win_cls = e_cls_r[near_idx];
    end
    if (e_few_r) begin
      vote_word.predicted_class  = '0;
      vote_word.nearest_distance = '0;
      vote_word.too_few_samples  = 1'b1;
    end else begin
      vote_word.predicted_class  = win_cls;
      vote_word.nearest_distance = best;
      vote_word.too_few_samples  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_go) begin
      slot_dist_r <= slot_dist_nxt;
      slot_cls_r  <= slot_cls_nxt;
      if (smp.last) begin
        e_dist_r <= slot_dist_nxt;
        e_cls_r  <= slot_cls_nxt;
        e_few_r  <= (seen_nxt != SEEN_FULL);
      end
    end
    if (e_go) begin
      out_word_r <= vote_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      e_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (smp_go) begin
        seen_r <= smp.last ? '0 : seen_nxt;
      end
      e_valid_r   <= (smp_go && smp.last) || (e_valid_r && !e_go);
      out_valid_r <= e_go || (out_valid_r && out_stall);
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // a set end always restarts the sample count
  `TNNC_ASSERT_NEXT(a_seen_clear, smp_go && smp.last, seen_r == '0)
  // with all slots filled, a sample can only bring a slot closer
  `TNNC_ASSERT_NEXT(a_full_no_grow, smp_go && seen_r == SEEN_FULL, (slot_dist_r[0] <= $past(slot_dist_r[0])) && (slot_dist_r[1] <= $past(slot_dist_r[1])) && (slot_dist_r[2] <= $past(slot_dist_r[2])))
  // a vote reports a distance no larger than snapshot slots zero and two
  `TNNC_ASSERT_NEXT(a_near_min, e_go && !e_few_r, out_valid_r && !out_word_r.too_few_samples && (out_word_r.nearest_distance <= $past(e_dist_r[0])) && (out_word_r.nearest_distance <= $past(e_dist_r[2])))

endmodule

`default_nettype wire

[sv/three_nearest_neighbour_classify_core.sv]
// top level of the three-nearest-neighbour classifier
//
//   channel  dir  handshake         word
//   in_      in   in_valid/in_stall  req_type, attr_value, sample_class, last_sample
//   out_     out  out_valid/out_stall predicted_class, nearest_distance, too_few_samples
//   cfg_     in   cfg_valid/cfg_ready attr_count (7 bits)
//
// one input word per cycle while in_stall is low; each attribute goes through query
// read, square and accumulate stages, followed by snapshot and result registers
// rst_n is synchronous; counters, accumulator and sample count restart at zero,
// attr_count at one, and the query store holds garbage until written
// a waiting result only stops the input once the snapshot stage behind it is
// also full; out_stall then backs up through the stages to in_stall
`default_nettype none

module three_nearest_neighbour_classify_core #(
  parameter int MAX_ATTRS = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  tnnc_pkg::in_word_t            in_word,
  output logic                          in_stall,
  output logic                          out_valid,
  output tnnc_pkg::out_word_t           out_word,
  input  logic                          out_stall,
  input  logic                          cfg_valid,
  input  logic [tnnc_pkg::CNT_BITS-1:0] cfg_data,
  output logic                          cfg_ready
);
  import tnnc_pkg::*;

  logic [CNT_BITS-1:0] attr_count_r;
  logic                smp_valid, smp_ready;
  sample_t             smp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_count_r <= CNT_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      attr_count_r <= cfg_data;
    end
  end

  tnnc_dist #(
    .MAX_ATTRS (MAX_ATTRS)
  ) u_dist (
    .clk        (clk),
    .rst_n      (rst_n),
    .attr_count (attr_count_r),
    .in_valid   (in_valid),
    .in_word    (in_word),
    .in_stall   (in_stall),
    .smp_valid  (smp_valid),
    .smp        (smp),
    .smp_ready  (smp_ready)
  );

  tnnc_slots u_slots (
    .clk       (clk),
    .rst_n     (rst_n),
    .smp_valid (smp_valid),
    .smp       (smp),
    .smp_ready (smp_ready),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall)
  );

endmodule

`default_nettype wire

[tb/three_nearest_neighbour_classify_core_tb.sv]
// self-checking testbench of the three-nearest-neighbour classifier core
module three_nearest_neighbour_classify_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tnnc_pkg::*;

  // no accepted word on any channel for this many cycles ends the run;
  // legitimate quiet stretches (register writes, drains, stalls) stay far below
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned NPHASES     = 8;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    in_word_t  word;
    logic      typed;
    out_word_t want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  in_word_t            in_word = '0;
  logic                in_stall;
  logic                out_valid;
  out_word_t           out_word;
  logic                out_stall = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CNT_BITS-1:0] cfg_data = '0;
  logic                cfg_ready;

  three_nearest_neighbour_classify_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // classifier mirror
  logic [VALUE_BITS-1:0] query_mirror [64];
  bit                    query_written [64];
  logic [CNT_BITS-1:0]   attr_cfg = 7'd1;
  int unsigned           attr_pos = 0;
  longint unsigned       dist_sum = 0;
  int unsigned           filled = 0;
  longint unsigned       slot_dist [NSLOTS] = '{0, 0, 0};
  logic [CLASS_BITS-1:0] slot_cls [NSLOTS] = '{0, 0, 0};

  out_word_t   votes_due [$];
  idle_mode_t  idle_mode = IDLE_NONE;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned votes_seen = 0;
  int unsigned short_sets = 0;
  int unsigned quiet_cycles = 0;

  int unsigned phase_cfg [NPHASES] = '{2, 3, 64, 1, 0, 127, 5, 3};
  int unsigned phase_len [NPHASES] = '{130, 130, 100, 80, 70, 100, 150, 140};

  // directed rows, all with attr_count at its reset value of one
  plan_row_t plan [24] = '{
    '{'{REQ_QUERY, 16'h0000, 8'h00, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'hffff, 8'haa, 1'b1}, 1'b1, '{8'h00, 38'd0, 1'b1}},
    '{'{REQ_TRAIN, 16'hffff, 8'h55, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h0000, 8'h55, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h0001, 8'haa, 1'b1}, 1'b1, '{8'h55, 38'd0, 1'b0}},
    '{'{REQ_QUERY, 16'hffff, 8'h00, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h0000, 8'h01, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'hffff, 8'h02, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h8000, 8'h03, 1'b1}, 1'b0, '0},
    '{'{REQ_QUERY, 16'h1000, 8'h00, 1'b0}, 1'b0, '0},
    // equal distances, then replacement of the lowest farthest slot
    '{'{REQ_TRAIN, 16'h1010, 8'h07, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h0ff0, 8'h08, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h1010, 8'h09, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h1000, 8'h0a, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h1008, 8'h0b, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h3000, 8'h0c, 1'b1}, 1'b0, '0},
    // majority on slots one and two, then on slots zero and two
    '{'{REQ_TRAIN, 16'h1000, 8'hff, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h1001, 8'h00, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h1002, 8'h00, 1'b1}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h1000, 8'hff, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h1001, 8'h00, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h1002, 8'hff, 1'b1}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h2000, 8'h33, 1'b0}, 1'b0, '0},
    '{'{REQ_TRAIN, 16'h2000, 8'h44, 1'b1}, 1'b1, '{8'h00, 38'd0, 1'b1}}
  };

  function automatic int unsigned active_count();
    if (attr_cfg == 0) return 1;
    if (attr_cfg > 64) return 64;
    return attr_cfg;
  endfunction

  function automatic int unsigned upcoming_index();
    return (attr_pos >= active_count()) ? 0 : attr_pos;
  endfunction

  function automatic int holdoff_pct(bit recv_side);
    if (idle_mode == IDLE_BOTH) return 13;
    if (idle_mode == (recv_side ? IDLE_RECV : IDLE_SEND)) return 69;
    return 0;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch: %s got %h want %h", what, got, want);
    mismatches++;
  endtask

  // advances the mirror by one accepted word; made is set when a vote comes out
  task automatic classify_step(input in_word_t w, output bit made, output out_word_t r);
    int unsigned     idx, f, near;
    longint unsigned diff, sq, best, cap;
    logic [CLASS_BITS-1:0] cls;
    bit              ends;
    made = 1'b0;
    r = '0;
    cap = 64'(DIST_MAX);
    idx = upcoming_index();
    ends = (idx + 1 >= active_count());
    attr_pos = ends ? 0 : idx + 1;
    if (w.req_type == REQ_QUERY) begin
      query_mirror[idx] = w.attr_value;
      query_written[idx] = 1'b1;
      return;
    end
    diff = (w.attr_value >= query_mirror[idx]) ? w.attr_value - query_mirror[idx]
                                               : query_mirror[idx] - w.attr_value;
    sq = diff * diff;
    dist_sum = (dist_sum > cap - sq) ? cap : dist_sum + sq;
    if (!ends) return;
    if (filled < NSLOTS) begin
      slot_dist[filled] = dist_sum;
      slot_cls[filled] = w.sample_class;
      filled++;
    end else begin
      f = 0;
      if (slot_dist[f] < slot_dist[1]) f = 1;
      if (slot_dist[f] < slot_dist[2]) f = 2;
      if (dist_sum < slot_dist[f]) begin
        slot_dist[f] = dist_sum;
        slot_cls[f] = w.sample_class;
      end
    end
    dist_sum = 0;
    if (!w.last_sample) return;
    made = 1'b1;
    if (filled < NSLOTS) begin
      r.too_few_samples = 1'b1;
      short_sets++;
    end else begin
      best = slot_dist[0];
      near = 0;
      for (int i = 1; i < NSLOTS; i++) begin
        if (best > slot_dist[i]) begin
          best = slot_dist[i];
          near = i;
        end
      end
      if (slot_cls[0] == slot_cls[1]) cls = slot_cls[1];
      else if (slot_cls[1] == slot_cls[2]) cls = slot_cls[1];
      else if (slot_cls[0] == slot_cls[2]) cls = slot_cls[0];
      else cls = slot_cls[near];
      r.predicted_class = cls;
      r.nearest_distance = best[DIST_BITS-1:0];
    end
    filled = 0;
  endtask

  // hands one word over; a training word that would read an unwritten
  // query entry is turned into a query word
  task automatic send_word(input in_word_t w, input bit typed, input out_word_t want);
    bit        made;
    out_word_t vote;
    if (w.req_type == REQ_TRAIN && !query_written[upcoming_index()])
      w.req_type = REQ_QUERY;
    while ($urandom_range(99) < holdoff_pct(1'b0)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    classify_step(w, made, vote);
    if (made) votes_due = {votes_due, (typed ? want : vote)};
  endtask

  task automatic drain_votes();
    in_valid <= 1'b0;
    do @(posedge clk); while (votes_due.size() != 0);
  endtask

  task automatic set_attr_count(int unsigned v);
    drain_votes();
    // words that make no vote may still be in the pipe
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v[CNT_BITS-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    attr_cfg = v[CNT_BITS-1:0];
  endtask

  task automatic send_noise();
    in_word_t w;
    w = in_word_t'({$urandom, $urandom});
    send_word(w, 1'b0, '0);
  endtask

  // one well-formed set: optional query refresh, then n_samples samples
  task automatic run_set(int unsigned n_samples);
    in_word_t              w;
    int unsigned           n, idx;
    bit                    refresh, ends;
    logic [CLASS_BITS-1:0] label;
    n = active_count();
    refresh = ($urandom_range(3) == 0);
    for (int i = 0; i < n; i++) if (!query_written[i]) refresh = 1'b1;
    if (refresh) begin
      for (int i = 0; i < n; i++) begin
        w = '0;
        w.req_type = REQ_QUERY;
        case ($urandom_range(7))
          0: w.attr_value = '0;
          1: w.attr_value = '1;
          default: w.attr_value = 16'($urandom);
        endcase
        w.sample_class = 8'($urandom);
        w.last_sample = 1'($urandom);
        send_word(w, 1'b0, '0);
      end
    end
    for (int s = 0; s < n_samples; s++) begin
      label = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
      do begin
        idx = upcoming_index();
        ends = (idx + 1 >= n);
        w.req_type = REQ_TRAIN;
        case ($urandom_range(3))
          0: w.attr_value = query_mirror[idx];
          1: w.attr_value = query_mirror[idx] ^ 16'($urandom_range(3));
          default: w.attr_value = 16'($urandom);
        endcase
        w.sample_class = ends ? label : 8'($urandom);
        w.last_sample = ends ? (s == n_samples - 1) : 1'($urandom);
        send_word(w, 1'b0, '0);
      end while (!ends);
    end
  endtask

  // result side: check and stall
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (votes_due.size() == 0) begin
        note_mismatch("result with none due", 64'(out_word), 64'd0);
      end else begin
        want = votes_due.pop_front();
        votes_seen++;
        if (out_word.predicted_class !== want.predicted_class)
          note_mismatch("predicted_class", 64'(out_word.predicted_class),
                        64'(want.predicted_class));
        if (out_word.nearest_distance !== want.nearest_distance)
          note_mismatch("nearest_distance", 64'(out_word.nearest_distance),
                        64'(want.nearest_distance));
        if (out_word.too_few_samples !== want.too_few_samples)
          note_mismatch("too_few_samples", 64'(out_word.too_few_samples),
                        64'(want.too_few_samples));
      end
    end
    out_stall <= ($urandom_range(99) < holdoff_pct(1'b1));
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("three_nearest_neighbour_classify_core regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned start, r;
    for (int i = 0; i < 64; i++) begin
      query_mirror[i] = '0;
      query_written[i] = 1'b0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want);

    for (int p = 0; p < NPHASES; p++) begin
      set_attr_count(phase_cfg[p]);
      idle_mode = idle_mode_t'(p % 4);
      start = words_sent;
      while (words_sent - start < phase_len[p]) begin
        if ($urandom_range(4) == 0)
          repeat ($urandom_range(1, 3)) send_noise();
        r = $urandom_range(15);
        run_set(r == 0 ? 1 : r == 1 ? 2 : 3 + $urandom_range(5));
        if ($urandom_range(9) == 0) drain_votes();
      end
    end

    drain_votes();
    repeat (20) @(posedge clk);
    if (votes_due.size() != 0)
      note_mismatch("results never seen", 64'(votes_due.size()), 64'd0);
    $display("covered %0d words and %0d votes (%0d short sets)", words_sent, votes_seen,
             short_sets);
    $display("attr_count settings 1, 2, 3, 5, 64 and out of range 0, 127; %0d mismatches",
             mismatches);
    if (mismatches == 0)
      $display("three_nearest_neighbour_classify_core regression: pass");
    else
      $display("three_nearest_neighbour_classify_core regression: fail");
    $finish;
  end

endmodule
